[design/hfpr_pkg.sv]
// ----------------------------------------------------------------------------
// Header-framed packet receiver package
// Transaction types, result kinds and header byte codes shared by the block.
// ----------------------------------------------------------------------------
package hfpr_pkg;

   // Input operation codes
   localparam logic OP_BYTE    = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   // Result kinds
   localparam logic [1:0] KIND_TX    = 2'd0;
   localparam logic [1:0] KIND_FRAME = 2'd1;
   localparam logic [1:0] KIND_ALIVE = 2'd2;

   // Header and type bytes
   localparam logic [7:0] HDR_FIRST      = 8'h4E;
   localparam logic [7:0] HDR_SECOND     = 8'h52;
   localparam logic [7:0] TYPE_HEARTBEAT = 8'h00;
   localparam logic [7:0] TYPE_FRAME     = 8'h01;

   // Header match progress
   localparam logic [1:0] HDR_IDLE = 2'd0;
   localparam logic [1:0] HDR_GOT1 = 2'd1;
   localparam logic [1:0] HDR_GOT2 = 2'd2;

   // Heartbeat reply positions
   localparam logic [1:0] HB_STEP_FIRST  = 2'd0;
   localparam logic [1:0] HB_STEP_SECOND = 2'd1;
   localparam logic [1:0] HB_STEP_LAST   = 2'd2;

   typedef struct packed {
      logic       op;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] value;
      logic [7:0] index;
      logic       alive;
      logic       frame_done;
      logic       last;
   } rsp_type;

   // Result group produced by one transaction, handed to the emitter
   typedef struct packed {
      logic       valid;
      logic       heartbeat;
      logic [1:0] kind;
      logic [7:0] value;
      logic [7:0] index;
      logic       alive;
      logic       frame_done;
   } burst_type;

endpackage

[design/hfpr_decoder.sv]
// ----------------------------------------------------------------------------
// Header-framed packet receiver decoder
// Holds the header and frame state and turns one transaction into a burst.
// ----------------------------------------------------------------------------
module hfpr_decoder (
   input  logic               clock,
   input  logic               reset,
   input  logic               take,
   input  hfpr_pkg::req_type   item,
   output hfpr_pkg::burst_type burst
);
   import hfpr_pkg::*;

   logic [1:0] header_count_ff, header_count_in;
   logic       in_frame_ff, in_frame_in;
   logic       frame_ready_ff, frame_ready_in;
   logic [7:0] write_index_ff, write_index_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] cur_length;

   // Decode the transaction against the current state
   always_comb begin
      header_count_in = header_count_ff;
      in_frame_in     = in_frame_ff;
      frame_ready_in  = frame_ready_ff;
      write_index_in  = write_index_ff;
      frame_length_in = frame_length_ff;
      burst           = '0;
      cur_length      = (write_index_ff == 8'd0) ? item.rx_byte : frame_length_ff;

      priority if (item.op == OP_RELEASE) begin
         frame_ready_in = 1'b0;
      end else if (frame_ready_ff) begin
         // drop bytes while a completed frame is pending
      end else if (in_frame_ff) begin
         frame_length_in  = cur_length;
         write_index_in   = write_index_ff + 8'd1;
         burst.valid      = 1'b1;
         burst.kind       = KIND_FRAME;
         burst.value      = item.rx_byte;
         burst.index      = write_index_ff;
         if (write_index_ff != 8'd0 && write_index_ff == cur_length) begin
            burst.frame_done = 1'b1;
            in_frame_in      = 1'b0;
            frame_ready_in   = 1'b1;
         end
      end else if (header_count_ff == HDR_IDLE && item.rx_byte == HDR_FIRST) begin
         header_count_in = HDR_GOT1;
      end else if (header_count_ff == HDR_GOT1 && item.rx_byte == HDR_SECOND) begin
         header_count_in = HDR_GOT2;
      end else if (header_count_ff == HDR_GOT2) begin
         header_count_in = HDR_IDLE;
         burst.valid     = 1'b1;
         burst.alive     = 1'b1;
         if (item.rx_byte == TYPE_HEARTBEAT) begin
            burst.heartbeat = 1'b1;
            burst.kind      = KIND_TX;
         end else begin
            burst.kind  = KIND_ALIVE;
            burst.value = item.rx_byte;
            if (item.rx_byte == TYPE_FRAME) begin
               write_index_in = 8'd0;
               in_frame_in    = 1'b1;
            end
         end
      end else begin
         header_count_in = HDR_IDLE;
      end
   end

   // Advance state on each taken transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         header_count_ff <= HDR_IDLE;
         in_frame_ff     <= 1'b0;
         frame_ready_ff  <= 1'b0;
         write_index_ff  <= 8'd0;
         frame_length_ff <= 8'd0;
      end else if (take) begin
         header_count_ff <= header_count_in;
         in_frame_ff     <= in_frame_in;
         frame_ready_ff  <= frame_ready_in;
         write_index_ff  <= write_index_in;
         frame_length_ff <= frame_length_in;
      end
   end

endmodule

[design/hfpr_emitter.sv]
// ----------------------------------------------------------------------------
// Header-framed packet receiver emitter
// Registers one burst and presents its results one per cycle while rsp_ready is high.
// ----------------------------------------------------------------------------
module hfpr_emitter (
   input  logic               clock,
   input  logic               reset,
   input  hfpr_pkg::burst_type load,
   output logic               load_ready,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output hfpr_pkg::rsp_type   rsp_data
);
   import hfpr_pkg::*;

   logic      valid_ff;
   burst_type burst_ff;
   logic [1:0] step_ff;
   logic      is_last;

   assign is_last    = !burst_ff.heartbeat || (step_ff == HB_STEP_LAST);
   assign load_ready = !valid_ff || (rsp_ready && is_last);
   assign rsp_valid  = valid_ff;

   // Build the current result from the held burst
   always_comb begin
      rsp_data            = '0;
      rsp_data.kind       = burst_ff.kind;
      rsp_data.index      = burst_ff.index;
      rsp_data.alive      = burst_ff.alive;
      rsp_data.frame_done = burst_ff.frame_done;
      rsp_data.last       = is_last;
      if (burst_ff.heartbeat) begin
         unique case (step_ff)
            HB_STEP_FIRST:  rsp_data.value = HDR_FIRST;
            HB_STEP_SECOND: rsp_data.value = HDR_SECOND;
            default:        rsp_data.value = TYPE_HEARTBEAT;
         endcase
      end else begin
         rsp_data.value = burst_ff.value;
      end
   end

   // Hold the burst control until its final result goes out
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= HB_STEP_FIRST;
      end else if (load_ready) begin
         valid_ff <= load.valid;
         step_ff  <= HB_STEP_FIRST;
      end else if (rsp_ready) begin
         step_ff <= step_ff + 2'd1;
      end
   end

   // Capture burst payload
   always_ff @(posedge clock) begin
      if (load_ready) begin
         burst_ff <= load;
      end
   end

endmodule

[design/header_framed_packet_receiver.sv]
// ----------------------------------------------------------------------------
// Header-framed packet receiver
// Hunts for the 'N','R' header on a byte stream and reports frames/heartbeats.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one transaction per handshake: a received byte (op 0) or a
//   release of a completed frame (op 1). rsp_* returns result transactions:
//   heartbeat reply bytes, frame bytes with their index, or a link-alive event;
//   rsp_data.last marks the final result of one request.
//   A request is accepted into the input register; its first result is then
//   registered in the result register and presented on rsp_*, and a stalled
//   result register holds the request in the input register meanwhile.
//   Requests are taken one per cycle while each causes at most one result and
//   rsp_ready is high; a heartbeat reply holds the single result register
//   until its three bytes are out, one byte per cycle while rsp_ready is high.
//   req_ready comes from a two-entry input register and does not depend on
//   rsp_ready combinationally; a stalled receiver fills both entries and then
//   drops req_ready, with no transaction lost.
//   Reset clears the header, frame and pending state and empties all stages;
//   bytes are ignored while a completed frame waits for a release request.
// ----------------------------------------------------------------------------
module header_framed_packet_receiver (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hfpr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hfpr_pkg::rsp_type rsp_data
);
   import hfpr_pkg::*;

   logic      main_valid_ff;
   req_type   main_ff;
   logic      skid_valid_ff;
   req_type   skid_ff;
   logic      accept;
   logic      take;
   logic      main_free;
   logic      emit_ready;
   burst_type burst;
   burst_type load;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign take      = main_valid_ff && emit_ready;
   assign main_free = !main_valid_ff || take;

   // Gate the burst so idle cycles load nothing
   always_comb begin
      load       = burst;
      load.valid = burst.valid && take;
   end

   // Advance the input register and its skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (main_free) begin
            main_valid_ff <= skid_valid_ff || accept;
         end
         if (skid_valid_ff && main_free) begin
            skid_valid_ff <= 1'b0;
         end else if (accept && !main_free) begin
            skid_valid_ff <= 1'b1;
         end
      end
   end

   // Move payloads
   always_ff @(posedge clock) begin
      if (main_free) begin
         main_ff <= skid_valid_ff ? skid_ff : req_data;
      end
      if (accept && !main_free) begin
         skid_ff <= req_data;
      end
   end

   hfpr_decoder u_decoder (
      .clock (clock),
      .reset (reset),
      .take  (take),
      .item  (main_ff),
      .burst (burst)
   );

   hfpr_emitter u_emitter (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .load_ready (emit_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_data   (rsp_data)
   );

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// Header-framed packet receiver testbench
// Drives byte and release transactions through the valid/ready request port
// with random gaps on both sides, predicts results with a cycle-free model of
// the header hunter and frame tracker (typed directed rows carry their own),
// and checks each returned result field by field in order. Runs, in order, a
// short directed table, a back-to-back burst into a stalled receiver, random
// heartbeat, frame, broken-header and noise sequences, and a zero-length frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import hfpr_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 250;
   localparam int DRAIN_CYCLES = 20;
   localparam int ITEM_TARGET  = 180;
   localparam int MAX_GAP      = 18;
   localparam int N_DIRECTED   = 23;
   localparam int TAIL_BYTES   = 12;

   typedef struct packed {
      req_type req;
      logic    typed;
      rsp_type want;
   } stim_row_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Receiver model state
   logic [1:0] hdr_match;
   logic       framing;
   logic       frame_pending;
   logic [7:0] next_index;
   logic [7:0] frame_len;

   rsp_type awaited_results[$];
   rsp_type step_results[$];
   rsp_type head_result;
   int      mismatch_count  = 0;
   int      sent_items      = 0;
   int      cycle_count     = 0;
   bit      no_idle         = 1'b0;
   bit      hold_off_req    = 1'b0;

   // Directed transactions; typed rows carry their result, others use the model
   stim_row_type directed_rows [N_DIRECTED] = '{
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_BYTE, HDR_SECOND}, 1'b0, '0},
      '{'{OP_BYTE, TYPE_HEARTBEAT}, 1'b0, '0},
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_BYTE, HDR_SECOND}, 1'b0, '0},
      '{'{OP_BYTE, 8'hFF}, 1'b1, '{KIND_ALIVE, 8'hFF, 8'h00, 1'b1, 1'b0, 1'b1}},
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_BYTE, HDR_SECOND}, 1'b0, '0},
      '{'{OP_BYTE, TYPE_FRAME}, 1'b0, '0},
      '{'{OP_RELEASE, 8'hFF}, 1'b0, '0},
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_BYTE, HDR_SECOND}, 1'b0, '0},
      '{'{OP_BYTE, TYPE_FRAME}, 1'b1, '{KIND_ALIVE, TYPE_FRAME, 8'h00, 1'b1, 1'b0, 1'b1}},
      '{'{OP_BYTE, 8'h02}, 1'b1, '{KIND_FRAME, 8'h02, 8'h00, 1'b0, 1'b0, 1'b1}},
      '{'{OP_BYTE, 8'hFF}, 1'b1, '{KIND_FRAME, 8'hFF, 8'h01, 1'b0, 1'b0, 1'b1}},
      '{'{OP_BYTE, 8'h00}, 1'b1, '{KIND_FRAME, 8'h00, 8'h02, 1'b0, 1'b1, 1'b1}},
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_RELEASE, 8'h00}, 1'b0, '0},
      '{'{OP_RELEASE, 8'hAA}, 1'b0, '0},
      '{'{OP_BYTE, HDR_FIRST}, 1'b0, '0},
      '{'{OP_BYTE, HDR_SECOND}, 1'b0, '0},
      '{'{OP_BYTE, TYPE_HEARTBEAT}, 1'b0, '0}
   };

   header_framed_packet_receiver dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // Clock and reset
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
   end

   // Advance the receiver model by one transaction; fill step_results
   function automatic void predict_results(input req_type t);
      rsp_type r;
      step_results.delete();
      r = '0;
      if (t.op == OP_RELEASE) begin
         frame_pending = 1'b0;
         return;
      end
      if (frame_pending)
         return;
      // Inside a frame every byte is payload
      if (framing) begin
         r.kind  = KIND_FRAME;
         r.value = t.rx_byte;
         r.index = next_index;
         r.last  = 1'b1;
         if (next_index == 8'd0)
            frame_len = t.rx_byte;
         if (next_index != 8'd0 && next_index == frame_len) begin
            r.frame_done  = 1'b1;
            framing       = 1'b0;
            frame_pending = 1'b1;
         end
         next_index = next_index + 8'd1;
         step_results.push_back(r);
         return;
      end
      // Header hunt
      if (hdr_match == HDR_IDLE && t.rx_byte == HDR_FIRST) begin
         hdr_match = HDR_GOT1;
         return;
      end
      if (hdr_match == HDR_GOT1 && t.rx_byte == HDR_SECOND) begin
         hdr_match = HDR_GOT2;
         return;
      end
      if (hdr_match == HDR_GOT2) begin
         hdr_match = HDR_IDLE;
         r.alive   = 1'b1;
         if (t.rx_byte == TYPE_HEARTBEAT) begin
            r.kind  = KIND_TX;
            r.value = HDR_FIRST;
            step_results.push_back(r);
            r.value = HDR_SECOND;
            step_results.push_back(r);
            r.value = TYPE_HEARTBEAT;
            r.last  = 1'b1;
            step_results.push_back(r);
            return;
         end
         if (t.rx_byte == TYPE_FRAME) begin
            next_index = 8'd0;
            framing    = 1'b1;
         end
         r.kind  = KIND_ALIVE;
         r.value = t.rx_byte;
         r.last  = 1'b1;
         step_results.push_back(r);
         return;
      end
      // Mismatch: restart the hunt
      hdr_match = HDR_IDLE;
   endfunction

   // Offer one transaction, wait for acceptance, record its results, then idle
   task automatic send_req(input req_type t, input bit typed, input rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data  <= t;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_results(t);
      sent_items++;
      if (typed)
         awaited_results.push_back(want);
      else
         foreach (step_results[i])
            awaited_results.push_back(step_results[i]);
      gap = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_byte(input logic [7:0] b);
      send_req('{OP_BYTE, b}, 1'b0, '0);
   endtask

   task automatic put_release();
      send_req('{OP_RELEASE, 8'($urandom_range(255, 0))}, 1'b0, '0);
   endtask

   // Drop valid and hold until every awaited result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (awaited_results.size() != 0)
         @(posedge clock);
   endtask

   // Open a frame with the given length byte and random payload, then release
   task automatic put_frame(input logic [7:0] len, input int n_payload);
      put_byte(HDR_FIRST);
      put_byte(HDR_SECOND);
      put_byte(TYPE_FRAME);
      put_byte(len);
      repeat (n_payload) put_byte(8'($urandom_range(255, 0)));
      // bytes while the frame is pending are dropped
      repeat ($urandom_range(2, 0)) put_byte(8'($urandom_range(255, 0)));
      put_release();
   endtask

   // Result receiver with random stalls and one long hold-off on request
   initial begin
      int w;
      while (reset)
         @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_off_req = 1'b0;
         end
         w = no_idle ? 0 : $urandom_range(MAX_GAP, 0);
         if (w > 0) begin
            rsp_ready <= 1'b0;
            repeat (w) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid && !hold_off_req)
            @(posedge clock);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Compare each result transaction with the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_results.size() == 0) begin
            $error("result with nothing awaited: kind %0h value %0h index %0h",
                   rsp_data.kind, rsp_data.value, rsp_data.index);
            mismatch_count++;
         end else begin
            head_result = awaited_results.pop_front();
            check_field("kind", 8'(head_result.kind), 8'(rsp_data.kind));
            check_field("value", head_result.value, rsp_data.value);
            check_field("index", head_result.index, rsp_data.index);
            check_field("alive", 8'(head_result.alive), 8'(rsp_data.alive));
            check_field("frame_done", 8'(head_result.frame_done),
                        8'(rsp_data.frame_done));
            check_field("last", 8'(head_result.last), 8'(rsp_data.last));
         end
      end
   end

   // Watchdog
   initial begin
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Stimulus
   initial begin
      int  pick;
      int  flen;
      hdr_match     = HDR_IDLE;
      framing       = 1'b0;
      frame_pending = 1'b0;
      next_index    = 8'd0;
      frame_len     = 8'd0;
      while (reset)
         @(posedge clock);

      // Walk the directed table
      foreach (directed_rows[i])
         send_req(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      // Stall the receiver while the sender keeps offering back to back
      hold_off_req = 1'b1;
      no_idle      = 1'b1;
      repeat (3) begin
         put_byte(HDR_FIRST);
         put_byte(HDR_SECOND);
         put_byte(TYPE_HEARTBEAT);
      end
      put_frame(8'd12, 12);
      no_idle = 1'b0;
      drain_results();

      // Random sequences, mostly well formed
      while (sent_items < ITEM_TARGET - TAIL_BYTES - 4) begin
         no_idle = ($urandom_range(7, 0) == 0);
         pick    = $urandom_range(99, 0);
         if (pick < 30) begin
            put_byte(HDR_FIRST);
            put_byte(HDR_SECOND);
            put_byte(TYPE_HEARTBEAT);
         end else if (pick < 62) begin
            // Complete frame: length byte, then one payload byte per index
            flen = $urandom_range(12, 1);
            put_frame(8'(flen), flen);
         end else if (pick < 70) begin
            put_byte(HDR_FIRST);
            put_byte(HDR_SECOND);
            put_byte(8'($urandom_range(255, 2)));
         end else if (pick < 82) begin
            // Broken header
            put_byte(HDR_FIRST);
            if ($urandom_range(1, 0))
               put_byte(HDR_FIRST);
            put_byte(8'($urandom_range(255, 0)));
            put_byte(8'($urandom_range(255, 0)));
         end else if (pick < 90) begin
            put_release();
         end else begin
            repeat ($urandom_range(4, 1)) put_byte(8'($urandom_range(255, 0)));
         end
         if ($urandom_range(19, 0) == 0)
            drain_results();
      end

      // Length zero: the frame does not complete at index zero and stays open
      no_idle = 1'b0;
      put_byte(HDR_FIRST);
      put_byte(HDR_SECOND);
      put_byte(TYPE_FRAME);
      put_byte(8'h00);
      repeat (TAIL_BYTES) put_byte(8'($urandom_range(255, 0)));

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && awaited_results.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

[filelist.f]
design/hfpr_pkg.sv
design/hfpr_decoder.sv
design/hfpr_emitter.sv
design/header_framed_packet_receiver.sv
verif/testbench.sv
